/* hw/rtl/pabr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pabr_pkg
// Shared types and constants for the premultiplied alpha blend run unit.
// ----------------------------------------------------------------------------
package pabr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0] ALPHA_ZERO = 8'd0;

  // configuration register indexes
  localparam logic [1:0] CFG_GLOBAL_ALPHA = 2'd0;
  localparam logic [1:0] CFG_TRANS_MASK   = 2'd1;
  localparam logic [1:0] CFG_OPAQUE_MASK  = 2'd2;

  // channel 3 is alpha
  typedef logic [3:0][7:0] pixel_t;

  typedef enum logic [2:0] {
    OP_KEEP,
    OP_COPY,
    OP_FULL,
    OP_SCALED,
    OP_SCALED_DZ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ga;
    pixel_t     src;
    pixel_t     dst;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* hw/rtl/pabr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pabr_front
// Holds configuration and run counters, classifies each request into a
// blend operation and pushes it to the queue.
// ----------------------------------------------------------------------------
module pabr_front import pabr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire pixel_t     in_src,
  input  wire pixel_t     in_dst,
  input  wire logic [7:0] in_trun,
  input  wire logic [7:0] in_orun,
  input  wire logic       in_row_end,
  input  wire q_status_t  q_status,
  output logic            push,
  output entry_t          push_data
);

  logic [7:0] ga_r;
  logic       tm_r;
  logic       om_r;
  logic [7:0] keep_left_r, keep_left_nxt;
  logic [7:0] copy_left_r, copy_left_nxt;
  op_t        op;
  logic       dst_zero;
  logic       src_zero;
  logic       src_full;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  assign dst_zero = (in_dst[3] == ALPHA_ZERO);
  assign src_zero = (in_src[3] == ALPHA_ZERO);
  assign src_full = (in_src[3] == ALPHA_FULL);

  always_comb begin
    op            = OP_KEEP;
    keep_left_nxt = keep_left_r;
    copy_left_nxt = copy_left_r;
    if (ga_r == ALPHA_ZERO) begin
      keep_left_nxt = '0;
      copy_left_nxt = '0;
    end else if (ga_r == ALPHA_FULL) begin
      if (tm_r && om_r) begin
        if (keep_left_r != '0) begin
          keep_left_nxt = keep_left_r - 8'd1;
        end else if (copy_left_r != '0) begin
          copy_left_nxt = copy_left_r - 8'd1;
          op            = OP_COPY;
        end else if (in_trun != '0) begin
          keep_left_nxt = in_trun - 8'd1;
        end else if (in_orun != '0) begin
          copy_left_nxt = in_orun - 8'd1;
          op            = OP_COPY;
        end else if (dst_zero) begin
          op = OP_COPY;
        end else begin
          op = OP_FULL;
        end
      end else begin
        keep_left_nxt = '0;
        copy_left_nxt = '0;
        if (src_zero) begin
          op = OP_KEEP;
        end else if (src_full || dst_zero) begin
          op = OP_COPY;
        end else begin
          op = OP_FULL;
        end
      end
    end else begin
      copy_left_nxt = '0;
      if (tm_r) begin
        if (keep_left_r != '0) begin
          keep_left_nxt = keep_left_r - 8'd1;
        end else if (in_trun != '0) begin
          keep_left_nxt = in_trun - 8'd1;
        end else begin
          op = dst_zero ? OP_SCALED_DZ : OP_SCALED;
        end
      end else begin
        keep_left_nxt = '0;
        if (!src_zero) begin
          op = dst_zero ? OP_SCALED_DZ : OP_SCALED;
        end
      end
    end
    if (in_row_end) begin
      keep_left_nxt = '0;
      copy_left_nxt = '0;
    end
  end

  assign push_data = '{op: op, ga: ga_r, src: in_src, dst: in_dst};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ga_r        <= ALPHA_FULL;
      tm_r        <= 1'b0;
      om_r        <= 1'b0;
      keep_left_r <= '0;
      copy_left_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLOBAL_ALPHA: ga_r <= cfg_wdata;
          CFG_TRANS_MASK:   tm_r <= cfg_wdata[0];
          CFG_OPAQUE_MASK:  om_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (push) begin
        keep_left_r <= keep_left_nxt;
        copy_left_r <= copy_left_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pabr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pabr_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module pabr_queue import pabr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      pop_data,
  output q_status_t   status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pabr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pabr_back
// Two-stage blend datapath with output register. Stage one forms the
// source-by-global-alpha products and the destination weight, stage two
// weights the destination and selects the result.
// ----------------------------------------------------------------------------
module pabr_back import pabr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  input  wire entry_t    q_data,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pixel_t         out_pix
);

  logic                   adv;
  logic                   s1_valid_r;
  op_t                    s1_op_r;
  pixel_t                 s1_src_r;
  pixel_t                 s1_dst_r;
  logic [3:0][15:0]       s1_sga_r;
  logic [7:0]             s1_wt_r;
  logic [15:0]            aga;
  logic [15:0]            w_full;
  logic [7:0]             wt;
  logic [3:0][15:0]       sga;
  logic [3:0][15:0]       dprod;
  logic [3:0][16:0]       ssum;
  pixel_t                 res;
  logic                   out_valid_r;
  pixel_t                 out_pix_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_status.empty;

  // stage one
  assign aga    = 16'(q_data.src[3]) * 16'(q_data.ga);
  assign w_full = 16'hFFFF - aga;
  assign wt     = (q_data.op == OP_FULL) ? (ALPHA_FULL - q_data.src[3]) : w_full[15:8];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sga[i] = 16'(q_data.src[i]) * 16'(q_data.ga);
    end
  end

  // stage two
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dprod[i] = 16'(s1_dst_r[i]) * 16'(s1_wt_r);
      ssum[i]  = 17'(s1_sga_r[i]) + 17'(dprod[i]);
      case (s1_op_r)
        OP_KEEP:      res[i] = s1_dst_r[i];
        OP_COPY:      res[i] = s1_src_r[i];
        OP_FULL:      res[i] = s1_src_r[i] + dprod[i][15:8];
        OP_SCALED:    res[i] = ssum[i][15:8];
        OP_SCALED_DZ: res[i] = s1_sga_r[i][15:8];
        default:      res[i] = s1_dst_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= q_data.op;
      s1_src_r  <= q_data.src;
      s1_dst_r  <= q_data.dst;
      s1_sga_r  <= sga;
      s1_wt_r   <= wt;
      out_pix_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule
`default_nettype wire

/* hw/rtl/premultiplied_alpha_blend_runs_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// premultiplied_alpha_blend_runs_unit
// Premultiplied source-over blend of one source/destination pixel pair per
// request, with global alpha and optional transparent/opaque run masks.
// ----------------------------------------------------------------------------
// One pixel pair is taken per cycle while in_ready is high. The front
// classifies the request and updates the run counters in the accept cycle
// and writes it into a FIFO of QUEUE_DEPTH_P entries at the accepting edge.
// From the FIFO the request is loaded into the first-stage registers of the
// two-stage multiply datapath and then into the output register that drives
// the outputs. With out_ready held high the unit sustains one request per
// cycle; when the output stalls, the FIFO absorbs up to QUEUE_DEPTH_P
// requests before in_ready drops. Configuration writes take effect on the
// next accepted request and are meant to be made while the unit is idle.
// ----------------------------------------------------------------------------
module premultiplied_alpha_blend_runs_unit import pabr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_src_c0,
  input  wire logic [7:0] in_src_c1,
  input  wire logic [7:0] in_src_c2,
  input  wire logic [7:0] in_src_alpha,
  input  wire logic [7:0] in_dst_c0,
  input  wire logic [7:0] in_dst_c1,
  input  wire logic [7:0] in_dst_c2,
  input  wire logic [7:0] in_dst_alpha,
  input  wire logic [7:0] in_transparent_run,
  input  wire logic [7:0] in_opaque_run,
  input  wire logic       in_row_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_c0,
  output logic [7:0]      out_c1,
  output logic [7:0]      out_c2,
  output logic [7:0]      out_alpha
);

  pixel_t    src_pix;
  pixel_t    dst_pix;
  pixel_t    res_pix;
  q_status_t q_status;
  logic      push;
  entry_t    push_data;
  logic      pop;
  entry_t    pop_data;

  assign src_pix = {in_src_alpha, in_src_c2, in_src_c1, in_src_c0};
  assign dst_pix = {in_dst_alpha, in_dst_c2, in_dst_c1, in_dst_c0};

  pabr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_src     (src_pix),
    .in_dst     (dst_pix),
    .in_trun    (in_transparent_run),
    .in_orun    (in_opaque_run),
    .in_row_end (in_row_end),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  pabr_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  pabr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (res_pix)
  );

  assign out_c0    = res_pix[0];
  assign out_c1    = res_pix[1];
  assign out_c2    = res_pix[2];
  assign out_alpha = res_pix[3];

endmodule
`default_nettype wire
